// ===== src/crc16_trailer_checker_defines.svh =====
// ---------------------------------------------------------------------------
// CRC16 trailer checker assertion macros
// Shared same-cycle/next-cycle implication checks, clocked on clk,
// disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CRC16_TRAILER_CHECKER_DEFINES_SVH
`define CRC16_TRAILER_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define CRC16TC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc16tc same-cycle check failed");

// Next-cycle implication.
`define CRC16TC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc16tc next-cycle check failed");

`endif

// ===== src/crc16tc_pkg.sv =====
// ---------------------------------------------------------------------------
// CRC16 trailer checker package
// Shared types, register indexes and the one-byte CRC update.
// ---------------------------------------------------------------------------
package crc16tc_pkg;

  localparam int unsigned HOLD_BYTES = 2;

  localparam logic [15:0] POLY_RESET = 16'h8005;
  localparam logic [15:0] FADD_RESET = 16'h0000;

  // Configuration register indexes.
  localparam logic CFG_IDX_POLY = 1'b0;
  localparam logic CFG_IDX_FADD = 1'b1;

  // Stream state as seen by the finalize stage.
  typedef struct packed {
    logic        pend;
    logic [15:0] rem;
    logic [7:0]  held0;
    logic [7:0]  held1;
  } crc16tc_snap_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = b[i];
    end
    return r;
  endfunction

  // Fold one byte into the remainder: reverse, XOR into the high byte,
  // then eight MSB-first shift steps.
  function automatic logic [15:0] crc_absorb(input logic [15:0] rem,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
    logic [15:0] r;
    r = rem ^ {bit_rev8(b), 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ poly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== src/crc16tc_stream.sv =====
// ---------------------------------------------------------------------------
// CRC16 trailer checker stream stage
// Holds the two-byte delay line and running remainder; flags a pending result.
// ---------------------------------------------------------------------------
`include "crc16_trailer_checker_defines.svh"

module crc16tc_stream (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_start_new,
  input  logic                       in_is_last,
  input  logic [15:0]                poly,
  input  logic                       take,
  output crc16tc_pkg::crc16tc_snap_t snap
);

  logic        pend_r, pend_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        in_accept;
  logic [15:0] rem_base;
  logic [7:0]  h0_base, h1_base;
  logic [1:0]  cnt_base;

  assign in_stall  = pend_r & ~take;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    // start clears the stream before this byte
    rem_base = in_start_new ? 16'h0000 : rem_r;
    h0_base  = in_start_new ? 8'h00 : held0_r;
    h1_base  = in_start_new ? 8'h00 : held1_r;
    cnt_base = in_start_new ? 2'd0 : cnt_r;

    rem_nxt   = rem_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r & ~take;

    if (in_accept) begin
      rem_nxt   = rem_base;
      held0_nxt = h0_base;
      held1_nxt = h1_base;
      if (cnt_base >= 2'(crc16tc_pkg::HOLD_BYTES)) begin
        // oldest byte leaves the delay line and enters the CRC
        rem_nxt   = crc16tc_pkg::crc_absorb(rem_base, h0_base, poly);
        held0_nxt = h1_base;
        held1_nxt = in_data_byte;
        cnt_nxt   = 2'(crc16tc_pkg::HOLD_BYTES);
      end else if (cnt_base == 2'd0) begin
        held0_nxt = in_data_byte;
        cnt_nxt   = 2'd1;
      end else begin
        held1_nxt = in_data_byte;
        cnt_nxt   = 2'd2;
      end
      pend_nxt = in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      rem_r   <= 16'h0000;
      held0_r <= 8'h00;
      held1_r <= 8'h00;
      cnt_r   <= 2'd0;
    end else begin
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign snap.pend  = pend_r;
  assign snap.rem   = rem_r;
  assign snap.held0 = held0_r;
  assign snap.held1 = held1_r;

  `CRC16TC_ASSERT_SAME(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `CRC16TC_ASSERT_NEXT(a_single_byte_stream,
                       in_accept && in_start_new && in_is_last,
                       pend_r && rem_r == 16'h0000 && cnt_r == 2'd1 && held1_r == 8'h00)
  `CRC16TC_ASSERT_SAME(a_stall_needs_pend, in_stall, pend_r)

endmodule

// ===== src/crc16tc_final.sv =====
// ---------------------------------------------------------------------------
// CRC16 trailer checker finalize stage
// Adds final_add if rem > poly, compares with the trailer, holds the result.
// ---------------------------------------------------------------------------
`include "crc16_trailer_checker_defines.svh"

module crc16tc_final (
  input  logic                       clk,
  input  logic                       rst_n,
  input  crc16tc_pkg::crc16tc_snap_t snap,
  input  logic [15:0]                poly,
  input  logic [15:0]                final_add,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_crc_value,
  output logic [15:0]                out_stored_checksum,
  output logic                       out_checksum_ok
);

  logic        vld_r, vld_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] stored_r, stored_nxt;
  logic        ok_r, ok_nxt;

  // move the pending result whenever the output register is free
  assign take = snap.pend & (~vld_r | ~out_stall);

  always_comb begin
    crc_nxt    = (snap.rem > poly) ? snap.rem + final_add : snap.rem;
    stored_nxt = {snap.held1, snap.held0};
    ok_nxt     = (crc_nxt == stored_nxt);
    vld_nxt    = take | (vld_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      crc_r    <= crc_nxt;
      stored_r <= stored_nxt;
      ok_r     <= ok_nxt;
    end
  end

  assign out_valid           = vld_r;
  assign out_crc_value       = crc_r;
  assign out_stored_checksum = stored_r;
  assign out_checksum_ok     = ok_r;

  `CRC16TC_ASSERT_NEXT(a_take_fills, take, vld_r)
  `CRC16TC_ASSERT_NEXT(a_ok_consistent, take, ok_r == (crc_r == stored_r))
  `CRC16TC_ASSERT_NEXT(a_out_hold, vld_r && out_stall, vld_r)

endmodule

// ===== src/crc16_trailer_checker.sv =====
// Result path: the accepting edge loads the stream state with the last byte;
// the result register then loads from it once the output register is free.
// Throughput: one byte per cycle; in_stall rises only while a finished result
// waits behind a stalled output register.
// Reset: synchronous active-low rst_n clears the stream state, pending flags,
// and restores polynomial 0x8005 and final addend 0x0000.
// ---------------------------------------------------------------------------
// CRC16 trailer checker top level
// Runs a bit-reversed-input CRC16 over a byte stream, excluding the last two
// bytes, and checks it against that little-endian trailer.
// ---------------------------------------------------------------------------
module crc16_trailer_checker (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_new,
  input  logic        in_is_last,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_crc_value,
  output logic [15:0] out_stored_checksum,
  output logic        out_checksum_ok,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] poly_r, poly_nxt;
  logic [15:0] fadd_r, fadd_nxt;
  logic        take;

  crc16tc_pkg::crc16tc_snap_t snap;

  // Config registers: load the addressed register on a write, hold otherwise.
  always_comb begin
    poly_nxt = poly_r;
    fadd_nxt = fadd_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        crc16tc_pkg::CFG_IDX_POLY: poly_nxt = cfg_data;
        crc16tc_pkg::CFG_IDX_FADD: fadd_nxt = cfg_data;
        default: begin
          poly_nxt = poly_r;
          fadd_nxt = fadd_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= crc16tc_pkg::POLY_RESET;
      fadd_r <= crc16tc_pkg::FADD_RESET;
    end else begin
      poly_r <= poly_nxt;
      fadd_r <= fadd_nxt;
    end
  end

  // Stream stage: absorb the byte pushed out of the delay line and flag a
  // pending result on the last byte. Hold the input while that result
  // cannot advance.
  crc16tc_stream u_stream (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_start_new (in_start_new),
    .in_is_last   (in_is_last),
    .poly         (poly_r),
    .take         (take),
    .snap         (snap)
  );

  // Finalize stage: add the final constant when the remainder exceeds the
  // polynomial, compare with the trailer, hold until the transaction is taken.
  crc16tc_final u_final (
    .clk                 (clk),
    .rst_n               (rst_n),
    .snap                (snap),
    .poly                (poly_r),
    .final_add           (fadd_r),
    .take                (take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_crc_value       (out_crc_value),
    .out_stored_checksum (out_stored_checksum),
    .out_checksum_ok     (out_checksum_ok)
  );

endmodule

// ===== verif/tb_crc16_trailer_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CRC16 trailer checker testbench
// Streams byte frames through the checker and compares every result against
// a cycle-free model of the stream state kept alongside the stimulus. A short
// directed pass covers short streams, extremes and continuation after a
// finalize. Random frames then run with correct or broken trailers under
// several polynomial and addend settings and input and output throttling.
// ---------------------------------------------------------------------------
module tb_crc16_trailer_checker;

  // Result as seen on the output channel.
  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] stored;
    logic        ok;
  } verdict_t;

  // One row of the directed pass. Rows with pinned set carry a hand-derived
  // result; the rest are checked against the stream model.
  typedef struct packed {
    logic [7:0]  data;
    logic        sof;
    logic        eof;
    logic        pinned;
    logic [15:0] crc;
    logic [15:0] stored;
    logic        ok;
  } dir_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int N_DIR       = 26;
  localparam int N_PHASES    = 8;
  localparam int PHASE_BYTES = 200;
  localparam int DRAIN_LIMIT = 20000;

  // Power-on settings: poly 0x8005, addend 0. Every pinned row below ends with
  // a zero remainder, so the CRC reads zero and only the trailer varies.
  localparam dir_row_t DIRECTED [N_DIR] = '{
    // no start before the first byte, one-byte stream of zero: match
    '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1},
    // one-byte stream, missing trailer byte reads as zero
    '{8'h5A, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h005A, 1'b0},
    // two-byte stream of all ones: nothing enters the CRC
    '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 1'b0},
    // little-endian trailer order
    '{8'h34, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h12, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h1234, 1'b0},
    // keep going after a finalize; each end of stream finalizes afresh
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h01, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    // plain longer stream
    '{8'h01, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h02, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h03, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h04, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h05, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h06, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    // start and end on the same byte
    '{8'hFF, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h00FF, 1'b0},
    // all-ones payload, then a continuation byte
    '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    // zero payload keeps the remainder at zero, zero trailer matches
    '{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_start_new = 1'b0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_crc_value;
  logic [15:0] out_stored_checksum;
  logic        out_checksum_ok;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = crc16tc_pkg::CFG_IDX_POLY;
  logic [15:0] cfg_data = 16'h0000;

  // Mirror of the configuration and of the stream state inside the block.
  logic [15:0] cur_poly;
  logic [15:0] cur_fadd;
  logic [15:0] str_rem;
  logic [7:0]  str_held [crc16tc_pkg::HOLD_BYTES];
  int unsigned str_cnt;

  verdict_t    verdict_q [$];
  verdict_t    got_v;
  verdict_t    want_v;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;

  crc16_trailer_checker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_new       (in_start_new),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_crc_value      (out_crc_value),
    .out_stored_checksum(out_stored_checksum),
    .out_checksum_ok    (out_checksum_ok),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs on either channel.
  initial begin
    #2000000;
    $display("crc16_trailer_checker verification failed");
    $finish;
  end

  // Push one byte through the remainder: mirror its bits into the high byte,
  // then run eight MSB-first shift steps.
  function automatic logic [15:0] fold_byte(input logic [15:0] rem, input logic [7:0] b,
                                            input logic [15:0] poly);
    logic [15:0] r;
    r = rem;
    for (int i = 0; i < 8; i++) begin
      r[15 - i] = r[15 - i] ^ b[i];
    end
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ poly) : (r << 1);
    end
    return r;
  endfunction

  // Add the end-of-stream addend if rem > poly; the running remainder stays.
  function automatic logic [15:0] finish_crc(input logic [15:0] rem);
    logic [15:0] sum;
    sum = rem + cur_fadd;
    return (rem > cur_poly) ? sum : rem;
  endfunction

  // Advance the stream model by one accepted byte and report its result.
  task automatic advance_stream(input logic [7:0] b, input logic sof, input logic eof,
                                output bit produced, output verdict_t v);
    if (sof) begin
      str_rem     = 16'h0000;
      str_held[0] = 8'h00;
      str_held[1] = 8'h00;
      str_cnt     = 0;
    end
    // The oldest held byte enters the CRC only once a newer one displaces it.
    if (str_cnt >= crc16tc_pkg::HOLD_BYTES) begin
      str_rem     = fold_byte(str_rem, str_held[0], cur_poly);
      str_held[0] = str_held[1];
      str_held[1] = b;
    end else begin
      str_held[str_cnt] = b;
      str_cnt++;
    end
    produced = eof;
    v.crc    = finish_crc(str_rem);
    v.stored = {str_held[1], str_held[0]};
    v.ok     = (v.crc == v.stored);
  endtask

  // Offer one byte transaction, hold it through stalls, then record its
  // result. A pinned result replaces the modeled one.
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof,
                           input bit pinned, input verdict_t pinned_v);
    bit       produced;
    verdict_t v;
    while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_start_new <= sof;
    in_is_last   <= eof;
    do @(posedge clk); while (in_stall);
    advance_stream(b, sof, eof, produced, v);
    if (produced) begin
      verdict_q = {verdict_q, (pinned ? pinned_v : v)};
    end
    bytes_sent++;
  endtask

  // Well-formed frame: random payload plus a two-byte trailer, correct most
  // of the time. Now and then end-of-stream also lands mid-frame.
  task automatic send_checked_frame();
    logic [7:0]  body [$];
    logic [15:0] rem;
    logic [15:0] crc;
    int          len;
    int          total;
    int          mid;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    rem = 16'h0000;
    for (int i = 0; i < len; i++) begin
      body = {body, 8'($urandom_range(0, 255))};
      rem = fold_byte(rem, body[i], cur_poly);
    end
    crc = finish_crc(rem);
    if ($urandom_range(0, 9) < 6) begin
      body = {body, crc[7:0]};
      body = {body, crc[15:8]};
    end else begin
      body = {body, 8'($urandom_range(0, 255))};
      body = {body, (($urandom_range(0, 1) == 1) ? crc[15:8] : 8'($urandom_range(0, 255)))};
    end
    total = body.size();
    mid   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total - 1;
    for (int i = 0; i < total; i++) begin
      send_byte(body[i], i == 0, (i == total - 1) || (i == mid), 1'b0, '0);
    end
  endtask

  // Noise: short bursts with random start and end flags.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 2) == 0, 1'b0, '0);
    end
  endtask

  // Drop valid and wait for every pending result, then let any byte with
  // no result settle in the pipeline.
  task automatic wait_for_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (verdict_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; only called with the block idle.
  task automatic write_cfg(input logic [15:0] poly, input logic [15:0] fadd);
    cfg_wr_en <= 1'b1;
    cfg_index <= crc16tc_pkg::CFG_IDX_POLY;
    cfg_data  <= poly;
    @(posedge clk);
    cfg_index <= crc16tc_pkg::CFG_IDX_FADD;
    cfg_data  <= fadd;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_poly = poly;
    cur_fadd = fadd;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        snd_idle_pct = 67;
        rcv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        snd_idle_pct = 0;
        rcv_stall_pct = 67;
      end
      default: begin
        snd_idle_pct = 16;
        rcv_stall_pct = 16;
      end
    endcase
  endtask

  // Throttle the result channel at random.
  always @(posedge clk) begin
    out_stall <= (rcv_stall_pct != 0) && ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Compare every result transaction with the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_v = '{out_crc_value, out_stored_checksum, out_checksum_ok};
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected result: crc %h stored %h ok %b",
                   $realtime, got_v.crc, got_v.stored, got_v.ok);
        end
      end else begin
        want_v = verdict_q.pop_front();
        if (got_v.crc !== want_v.crc || got_v.stored !== want_v.stored ||
            got_v.ok !== want_v.ok) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result mismatch: crc %h/%h stored %h/%h ok %b/%b (want/got)",
                     $realtime, want_v.crc, got_v.crc, want_v.stored, got_v.stored,
                     want_v.ok, got_v.ok);
          end
        end
      end
    end
  end

  initial begin
    verdict_t pin_v;
    int       phase_end;
    cur_poly    = crc16tc_pkg::POLY_RESET;
    cur_fadd    = crc16tc_pkg::FADD_RESET;
    str_rem     = 16'h0000;
    str_held[0] = 8'h00;
    str_held[1] = 8'h00;
    str_cnt     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at power-on settings, no throttling.
    set_idle(IDLE_NONE);
    for (int r = 0; r < N_DIR; r++) begin
      pin_v = '{DIRECTED[r].crc, DIRECTED[r].stored, DIRECTED[r].ok};
      send_byte(DIRECTED[r].data, DIRECTED[r].sof, DIRECTED[r].eof,
                DIRECTED[r].pinned, pin_v);
    end

    // Random phases: reprogram between phases with the block drained, and
    // rotate the throttling pattern so stalls hit every point of a frame.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_for_idle();
      case (p)
        0: write_cfg(16'h8005, 16'h0000);
        1: write_cfg(16'h0000, 16'h0000);
        2: write_cfg(16'hFFFF, 16'hFFFF);
        3: write_cfg(16'h1021, 16'h1234);
        4: write_cfg(16'h0000, 16'hFFFF);
        7: write_cfg(16'hA001, 16'h0001);
        default: write_cfg(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      set_idle(idle_mode_t'(p % 4));
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          send_checked_frame();
        end else begin
          send_noise();
        end
      end
    end

    wait_for_idle();
    // Anything still pending never arrived.
    mismatches += verdict_q.size();
    if (mismatches == 0) begin
      $display("crc16_trailer_checker verification clean");
    end else begin
      $display("crc16_trailer_checker verification failed");
    end
    $finish;
  end

endmodule
